// ----- hdl/pls_pkg.sv -----
// Package with the shared types and constants of the positional list store.
package pls_pkg;

  localparam int DEF_CAPACITY = 16;
  localparam int DATA_W       = 32;

  typedef enum logic [2:0] {
    MODE_APPEND  = 3'd0,
    MODE_PREPEND = 3'd1,
    MODE_INSERT  = 3'd2,
    MODE_READ    = 3'd3,
    MODE_DELETE  = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BAD_POS = 2'd1,
    ST_FULL    = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD = 2'd0,
    CELL_INS  = 2'd1,
    CELL_DEL  = 2'd2
  } cell_op_t;

  typedef struct packed {
    cell_op_t                 op;
    logic signed [DATA_W-1:0] value;
  } cell_cmd_t;

endpackage

// ----- hdl/positional_list_store.sv -----
// Top level of the positional list store: request decode, cell row and result register.
//
// Usage: each input word carries a mode (append, prepend, insert at index,
// read at index, delete at index), a position and a value. Every accepted
// word produces exactly one result word with read_value, status and count.
// The list lives in a row of CAPACITY cells; an insert shifts the cells at
// and after the index back by one place, and a delete shifts the later
// cells forward by one place.
// The result word is registered and is valid in the cycle after the
// input word is accepted. Throughput is one word per cycle while the receiver
// takes each result, set by the cell row update and the one-entry result register.
// When the receiver stalls, the result register holds its word and the
// input channel accepts a new word only in a cycle in which the held result
// is taken, so no result is lost.
// Reset empties the list (count zero) and clears the result valid flag;
// cell contents are not cleared and are only read below the count.
module positional_list_store import pls_pkg::*; #(
  parameter int CAPACITY = DEF_CAPACITY,
  parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [2:0]               in_mode,
  input  logic [CNT_W-1:0]         in_position,
  input  logic signed [DATA_W-1:0] in_value,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [DATA_W-1:0] out_read_value,
  output logic [1:0]               out_status,
  output logic [CNT_W-1:0]         out_count
);

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  logic                     accept;
  logic [CNT_W-1:0]         count_r;
  logic [CNT_W-1:0]         count_nxt;
  logic                     out_valid_r;
  logic                     out_valid_nxt;
  logic signed [DATA_W-1:0] out_read_value_r;
  logic signed [DATA_W-1:0] read_value_nxt;
  status_t                  out_status_r;
  status_t                  status_nxt;
  logic [CNT_W-1:0]         out_count_r;
  cell_cmd_t                cmd;
  logic [CNT_W-1:0]         op_pos;
  logic signed [DATA_W-1:0] cell_data [CAPACITY];

  assign accept   = in_valid && in_ready;
  assign in_ready = !out_valid_r || out_ready;

  always_comb begin
    cmd.op         = CELL_HOLD;
    cmd.value      = in_value;
    op_pos         = in_position;
    status_nxt     = ST_OK;
    read_value_nxt = '0;
    count_nxt      = count_r;
    unique case (mode_t'(in_mode)) inside
      MODE_APPEND, MODE_PREPEND, MODE_INSERT: begin
        if (mode_t'(in_mode) == MODE_APPEND) begin
          op_pos = count_r;
        end else if (mode_t'(in_mode) == MODE_PREPEND) begin
          op_pos = '0;
        end
        if (op_pos > count_r) begin
          status_nxt = ST_BAD_POS;
        end else if (count_r >= CAP_CNT) begin
          status_nxt = ST_FULL;
        end else begin
          cmd.op    = CELL_INS;
          count_nxt = count_r + 1'b1;
        end
      end
      MODE_READ: begin
        if (in_position < count_r) begin
          read_value_nxt = cell_data[in_position[IDX_W-1:0]];
        end else begin
          read_value_nxt = -32'sd1;
          status_nxt     = ST_BAD_POS;
        end
      end
      MODE_DELETE: begin
        if (in_position < count_r) begin
          cmd.op    = CELL_DEL;
          count_nxt = count_r - 1'b1;
        end else begin
          status_nxt = ST_BAD_POS;
        end
      end
      default: status_nxt = ST_BAD_POS;
    endcase
    if (!accept) begin
      cmd.op    = CELL_HOLD;
      count_nxt = count_r;
    end
  end

  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      logic signed [DATA_W-1:0] left_w;
      logic signed [DATA_W-1:0] right_w;
      if (gi == 0) begin : g_first
        assign left_w = '0;
      end else begin : g_mid_l
        assign left_w = cell_data[gi-1];
      end
      if (gi == CAPACITY - 1) begin : g_last
        assign right_w = '0;
      end else begin : g_mid_r
        assign right_w = cell_data[gi+1];
      end
      pls_cell #(
        .CNT_W (CNT_W),
        .INDEX (gi)
      ) u_cell (
        .clk        (clk),
        .cmd        (cmd),
        .pos        (op_pos),
        .left_data  (left_w),
        .right_data (right_w),
        .data       (cell_data[gi])
      );
    end
  endgenerate

  assign out_valid_nxt = accept || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_read_value_r <= read_value_nxt;
      out_status_r     <= status_nxt;
      out_count_r      <= count_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_read_value = out_read_value_r;
  assign out_status     = out_status_r;
  assign out_count      = out_count_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CAP_CNT)
    else $error("element count exceeds capacity");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid_r && out_count_r == count_r)
    else $error("result word missing or count mismatch");

  a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !accept |=> $stable(count_r))
    else $error("count changed without an accepted word");

  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    accept && status_nxt == ST_FULL |-> count_r == CAP_CNT)
    else $error("full status reported on a list that is not full");

endmodule

// ----- hdl/pls_cell.sv -----
// One list cell: holds one element and shifts toward or away from its neighbors.
module pls_cell import pls_pkg::*; #(
  parameter int CNT_W = 5,
  parameter int INDEX = 0
) (
  input  logic                     clk,
  input  cell_cmd_t                cmd,
  input  logic [CNT_W-1:0]         pos,
  input  logic signed [DATA_W-1:0] left_data,
  input  logic signed [DATA_W-1:0] right_data,
  output logic signed [DATA_W-1:0] data
);

  localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(INDEX);

  logic signed [DATA_W-1:0] data_r;
  logic signed [DATA_W-1:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    case (cmd.op)
      CELL_INS: begin
        if (MY_IDX > pos) begin
          data_nxt = left_data;
        end else if (MY_IDX == pos) begin
          data_nxt = cmd.value;
        end
      end
      CELL_DEL: begin
        if (MY_IDX >= pos) begin
          data_nxt = right_data;
        end
      end
      default: data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;

endmodule
